// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the recall unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define STNR_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// condition must never be true outside reset
`define STNR_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

// File: rtl/stnr_pkg.sv
// ----------------------------------------------------------------------------
// stnr_pkg
// Types, constants and helpers shared by the story table recall unit.
// ----------------------------------------------------------------------------
package stnr_pkg;

  localparam int MAX_ENTRIES      = 64;
  localparam int VECTOR_DIM       = 4;
  localparam int IDX_W            = $clog2(MAX_ENTRIES);
  localparam int CNT_W            = IDX_W + 1;
  localparam int COMP_W           = (VECTOR_DIM > 1) ? $clog2(VECTOR_DIM) : 1;
  localparam int COMP_BITS        = 16;
  localparam int DIST_W           = 2 * COMP_BITS + 2;
  localparam int STAMP_W          = 32;
  localparam int RATE_W           = 16;
  localparam int ID_W             = 7;
  localparam int WANT_W           = 7;
  localparam logic [RATE_W-1:0]  DEFAULT_RATE     = 16'd410;
  localparam logic [31:0]        FADE_LIMIT_RESET = 32'd18863;

  typedef enum logic [1:0] {
    ACT_STORE   = 2'd0,
    ACT_DERIVED = 2'd1,
    ACT_DECAY   = 2'd2,
    ACT_RECALL  = 2'd3
  } stnr_action_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_PRD,
    S_SWR,
    S_DRD,
    S_DMUL,
    S_DWR,
    S_VRD,
    S_VSQ,
    S_VACC,
    S_VWR,
    S_SCHK,
    S_SRD,
    S_SCMP,
    S_SEMIT,
    S_NONE
  } stnr_state_e;

  typedef struct packed {
    logic [1:0]              action;
    logic signed [15:0]      vec_0;
    logic signed [15:0]      vec_1;
    logic signed [15:0]      vec_2;
    logic signed [15:0]      vec_3;
    logic [STAMP_W-1:0]      time_value;
    logic [RATE_W-1:0]       fade_rate;
    logic [ID_W-1:0]         parent_ref;
    logic [WANT_W-1:0]       neighbours_wanted;
  } stnr_req_t;

  typedef struct packed {
    logic [ID_W-1:0] entry_id;
    logic            found;
    logic            last_item;
  } stnr_rsp_t;

  typedef struct packed {
    logic load;
    logic clr_idx;
    logic inc_idx;
    logic prd;
    logic swr;
    logic dmul;
    logic dwr;
    logic recall_init;
    logic vrd;
    logic vsq;
    logic vacc;
    logic vwr;
    logic sel_start;
    logic scmp;
    logic semit;
    logic emit_none;
  } stnr_cmd_t;

  typedef struct packed {
    stnr_action_e action;
    logic         full;
    logic         count_zero;
    logic         idx_last;
    logic         comp_last;
    logic         total_zero;
    logic         sel_last;
  } stnr_status_t;

  function automatic logic [COMP_BITS-1:0] req_vec(input stnr_req_t r, input logic [1:0] d);
    logic [COMP_BITS-1:0] v;
    case (d)
      2'd0:    v = r.vec_0;
      2'd1:    v = r.vec_1;
      2'd2:    v = r.vec_2;
      default: v = r.vec_3;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/stnr_datapath.sv
// ----------------------------------------------------------------------------
// stnr_datapath
// Entry memories, fade marks, distance unit, decay test and result register.
// ----------------------------------------------------------------------------
module stnr_datapath import stnr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  stnr_req_t    req_i,
  input  logic         cfg_we_i,
  input  logic [31:0]  cfg_wdata_i,
  input  stnr_cmd_t    cmd_i,
  output stnr_status_t status_o,
  output stnr_rsp_t    rsp_o,
  output logic         rsp_valid_o
);

  logic [VECTOR_DIM-1:0][COMP_BITS-1:0] vec_mem [MAX_ENTRIES];
  logic [STAMP_W-1:0]                   stamp_mem [MAX_ENTRIES];
  logic [RATE_W-1:0]                    rate_mem [MAX_ENTRIES];
  logic [DIST_W-1:0]                    dist_mem [MAX_ENTRIES];

  logic [VECTOR_DIM-1:0][COMP_BITS-1:0] vec_rd_q;
  logic [STAMP_W-1:0]                   stamp_rd_q;
  logic [RATE_W-1:0]                    rate_rd_q;
  logic [DIST_W-1:0]                    dist_rd_q;

  stnr_req_t          req_q;
  logic [31:0]        fade_limit_q;
  logic [CNT_W-1:0]   count_q;
  logic [IDX_W-1:0]   idx_q;
  logic [COMP_W-1:0]  comp_q;
  logic [DIST_W-1:0]  acc_q;
  logic [DIST_W-1:0]  sq_q;
  logic signed [49:0] prod_q;
  logic               have_q;
  logic [IDX_W-1:0]   best_q;
  logic [DIST_W-1:0]  best_dist_q;
  logic [CNT_W-1:0]   avail_q;
  logic [CNT_W-1:0]   n_q;
  logic [MAX_ENTRIES-1:0] faded_q;
  logic [MAX_ENTRIES-1:0] taken_q;
  stnr_rsp_t          rsp_q;
  logic               rsp_valid_q;

  logic [VECTOR_DIM-1:0][COMP_BITS-1:0] vec_wr;
  logic [ID_W-1:0]    pid_m1;
  logic               pid_ok;
  logic [RATE_W-1:0]  store_rate;
  logic [IDX_W-1:0]   rate_addr;
  logic signed [32:0] age;
  logic signed [49:0] prod_d;
  logic signed [16:0] diff;
  logic signed [33:0] sq_full;
  logic [COMP_BITS-1:0] q_comp;
  logic [COMP_BITS-1:0] s_comp;
  logic [CNT_W-1:0]   total;
  logic [CNT_W-1:0]   want;

  always_comb begin
    for (int d = 0; d < VECTOR_DIM; d++) begin
      vec_wr[d] = req_vec(req_q, 2'(d));
    end
  end

  assign pid_m1     = req_q.parent_ref - 7'd1;
  assign pid_ok     = (req_q.parent_ref != '0) && (CNT_W'(req_q.parent_ref) <= count_q);
  assign rate_addr  = cmd_i.prd ? pid_m1[IDX_W-1:0] : idx_q;
  assign store_rate = (stnr_action_e'(req_q.action) == ACT_DERIVED) ?
                      (pid_ok ? rate_rd_q : DEFAULT_RATE) : req_q.fade_rate;

  assign age     = $signed({1'b0, req_q.time_value}) - $signed({1'b0, stamp_rd_q});
  assign prod_d  = $signed({1'b0, rate_rd_q}) * age;

  assign q_comp  = req_vec(req_q, 2'(comp_q));
  assign s_comp  = vec_rd_q[comp_q];
  assign diff    = $signed({q_comp[COMP_BITS-1], q_comp}) - $signed({s_comp[COMP_BITS-1], s_comp});
  assign sq_full = diff * diff;

  assign want    = CNT_W'(req_q.neighbours_wanted);
  assign total   = (want < avail_q) ? want : avail_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.swr) begin
      vec_mem[count_q[IDX_W-1:0]]   <= vec_wr;
      stamp_mem[count_q[IDX_W-1:0]] <= req_q.time_value;
      rate_mem[count_q[IDX_W-1:0]]  <= store_rate;
    end
    if (cmd_i.vwr) begin
      dist_mem[idx_q] <= acc_q;
    end
    vec_rd_q   <= vec_mem[idx_q];
    stamp_rd_q <= stamp_mem[idx_q];
    rate_rd_q  <= rate_mem[rate_addr];
    dist_rd_q  <= dist_mem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q        <= '0;
      fade_limit_q <= FADE_LIMIT_RESET;
      count_q      <= '0;
      idx_q        <= '0;
      comp_q       <= '0;
      acc_q        <= '0;
      sq_q         <= '0;
      prod_q       <= '0;
      have_q       <= 1'b0;
      best_q       <= '0;
      best_dist_q  <= '0;
      avail_q      <= '0;
      n_q          <= '0;
      faded_q      <= '0;
      taken_q      <= '0;
      rsp_q        <= '0;
      rsp_valid_q  <= 1'b0;
    end else begin
      rsp_valid_q <= 1'b0;
      if (cfg_we_i) begin
        fade_limit_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        req_q <= req_i;
      end
      if (cmd_i.clr_idx) begin
        idx_q <= '0;
      end
      if (cmd_i.inc_idx) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.swr) begin
        faded_q[count_q[IDX_W-1:0]] <= 1'b0;
        count_q     <= count_q + 1'b1;
        rsp_q       <= '{entry_id: ID_W'(count_q) + 7'd1, found: 1'b1, last_item: 1'b1};
        rsp_valid_q <= 1'b1;
      end
      if (cmd_i.dmul) begin
        prod_q <= prod_d;
      end
      if (cmd_i.dwr) begin
        faded_q[idx_q] <= prod_q > $signed({18'b0, fade_limit_q});
      end
      if (cmd_i.recall_init) begin
        taken_q <= '1;
        avail_q <= '0;
        n_q     <= '0;
      end
      if (cmd_i.vrd) begin
        comp_q <= '0;
        acc_q  <= '0;
      end
      if (cmd_i.vsq) begin
        sq_q <= DIST_W'(unsigned'(sq_full));
      end
      if (cmd_i.vacc) begin
        acc_q  <= acc_q + sq_q;
        comp_q <= comp_q + 1'b1;
      end
      if (cmd_i.vwr) begin
        taken_q[idx_q] <= faded_q[idx_q];
        if (!faded_q[idx_q]) begin
          avail_q <= avail_q + 1'b1;
        end
      end
      if (cmd_i.sel_start) begin
        have_q <= 1'b0;
      end
      if (cmd_i.scmp) begin
        if (!taken_q[idx_q] && (!have_q || (dist_rd_q < best_dist_q))) begin
          have_q      <= 1'b1;
          best_q      <= idx_q;
          best_dist_q <= dist_rd_q;
        end
      end
      if (cmd_i.semit) begin
        taken_q[best_q] <= 1'b1;
        n_q             <= n_q + 1'b1;
        rsp_q           <= '{entry_id: ID_W'(best_q) + 7'd1, found: 1'b1,
                             last_item: status_o.sel_last};
        rsp_valid_q     <= 1'b1;
      end
      if (cmd_i.emit_none) begin
        rsp_q       <= '{entry_id: '0, found: 1'b0, last_item: 1'b1};
        rsp_valid_q <= 1'b1;
      end
    end
  end

  always_comb begin
    status_o.action     = stnr_action_e'(req_q.action);
    status_o.full       = (count_q == CNT_W'(MAX_ENTRIES));
    status_o.count_zero = (count_q == '0);
    status_o.idx_last   = (CNT_W'(idx_q) == count_q - 1'b1);
    status_o.comp_last  = (comp_q == COMP_W'(VECTOR_DIM - 1));
    status_o.total_zero = (total == '0);
    status_o.sel_last   = (n_q + 1'b1 == total);
  end

  assign rsp_o       = rsp_q;
  assign rsp_valid_o = rsp_valid_q;

endmodule

// File: rtl/stnr_ctrl.sv
// ----------------------------------------------------------------------------
// stnr_ctrl
// Sequencer for store, decay sweep, distance sweep and nearest selection.
// ----------------------------------------------------------------------------
module stnr_ctrl import stnr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  input  stnr_status_t status_i,
  output stnr_cmd_t    cmd_o,
  output logic         busy
);

  stnr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (start) state_d = S_DISP;
      S_DISP: begin
        case (status_i.action)
          ACT_STORE:   state_d = status_i.full ? S_NONE : S_SWR;
          ACT_DERIVED: state_d = status_i.full ? S_NONE : S_PRD;
          ACT_DECAY:   state_d = status_i.count_zero ? S_NONE : S_DRD;
          default:     state_d = status_i.count_zero ? S_NONE : S_VRD;
        endcase
      end
      S_PRD:   state_d = S_SWR;
      S_SWR:   state_d = S_IDLE;
      S_DRD:   state_d = S_DMUL;
      S_DMUL:  state_d = S_DWR;
      S_DWR:   state_d = status_i.idx_last ? S_NONE : S_DRD;
      S_VRD:   state_d = S_VSQ;
      S_VSQ:   state_d = S_VACC;
      S_VACC:  state_d = status_i.comp_last ? S_VWR : S_VSQ;
      S_VWR:   state_d = status_i.idx_last ? S_SCHK : S_VRD;
      S_SCHK:  state_d = status_i.total_zero ? S_NONE : S_SRD;
      S_SRD:   state_d = S_SCMP;
      S_SCMP:  state_d = status_i.idx_last ? S_SEMIT : S_SRD;
      S_SEMIT: state_d = status_i.sel_last ? S_IDLE : S_SRD;
      S_NONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE:  cmd_o.load = start;
      S_DISP: begin
        cmd_o.clr_idx     = 1'b1;
        cmd_o.recall_init = (status_i.action == ACT_RECALL);
      end
      S_PRD:   cmd_o.prd = 1'b1;
      S_SWR:   cmd_o.swr = 1'b1;
      S_DMUL:  cmd_o.dmul = 1'b1;
      S_DWR: begin
        cmd_o.dwr     = 1'b1;
        cmd_o.inc_idx = !status_i.idx_last;
      end
      S_VRD:   cmd_o.vrd = 1'b1;
      S_VSQ:   cmd_o.vsq = 1'b1;
      S_VACC:  cmd_o.vacc = 1'b1;
      S_VWR: begin
        cmd_o.vwr     = 1'b1;
        cmd_o.inc_idx = !status_i.idx_last;
      end
      S_SCHK: begin
        cmd_o.clr_idx   = 1'b1;
        cmd_o.sel_start = 1'b1;
      end
      S_SCMP: begin
        cmd_o.scmp    = 1'b1;
        cmd_o.inc_idx = !status_i.idx_last;
      end
      S_SEMIT: begin
        cmd_o.semit     = 1'b1;
        cmd_o.clr_idx   = 1'b1;
        cmd_o.sel_start = 1'b1;
      end
      S_NONE:  cmd_o.emit_none = 1'b1;
      default: cmd_o = '0;
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

// File: rtl/story_table_nearest_recall_unit.sv
// One transaction at a time; the decay and distance sweeps and the selection
// scans walk the entry memories one entry per step.
// Results appear one per strobe cycle; the receiver cannot stall them.
// Reset (async, active low) empties the table and restores fade_limit.
// ----------------------------------------------------------------------------
// story_table_nearest_recall_unit
// Story table with fade tracking and k-nearest recall, top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module story_table_nearest_recall_unit import stnr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  stnr_req_t   req_i,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  output logic        result_strobe_o,
  output stnr_rsp_t   rsp_o
);

  stnr_cmd_t    cmd;
  stnr_status_t status;

  stnr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  stnr_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .rsp_o       (rsp_o),
    .rsp_valid_o (result_strobe_o)
  );

  `STNR_ASSERT(a_start_busy, clk_i, rst_ni, (start && !busy) |=> busy)
  `STNR_ASSERT(a_result_after_busy, clk_i, rst_ni, result_strobe_o |-> $past(busy))
  `STNR_NEVER(a_found_zero_id, clk_i, rst_ni, result_strobe_o && rsp_o.found && (rsp_o.entry_id == '0))
  `STNR_NEVER(a_miss_not_last, clk_i, rst_ni, result_strobe_o && !rsp_o.found && !rsp_o.last_item)

endmodule
